// File: design/tws_pkg.sv
package tws_pkg;

  localparam int unsigned FIELD_W       = 32;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned STAMP_W       = 18;
  localparam int unsigned CHANNELS      = 6;
  localparam int unsigned WRAP_CHANNELS = 3;
  localparam int unsigned CH_W          = 3;

  // pi in Q3.28, truncated
  localparam logic [63:0] PI_Q28       = 64'd843314856;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd5000;

  typedef struct packed {
    logic        [15:0] time_delta_ms;
    logic signed [31:0] bank_in;
    logic signed [31:0] pitch_in;
    logic signed [31:0] heading_in;
    logic signed [31:0] lat_in;
    logic signed [31:0] lon_in;
    logic signed [31:0] alt_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] bank_avg;
    logic signed [31:0] pitch_avg;
    logic signed [31:0] heading_avg;
    logic signed [31:0] lat_avg;
    logic signed [31:0] lon_avg;
    logic signed [31:0] alt_avg;
  } out_t;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_LAST     = 11'b00000000010,
    S_EXCESS   = 11'b00000000100,
    S_DROP_RD  = 11'b00000001000,
    S_DROP_CHK = 11'b00000010000,
    S_FULL     = 11'b00000100000,
    S_APPEND   = 11'b00001000000,
    S_SUM      = 11'b00010000000,
    S_SUM_END  = 11'b00100000000,
    S_DIV      = 11'b01000000000,
    S_OUT      = 11'b10000000000
  } state_e;

endpackage

// File: design/tws_stream_if.sv
interface tws_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: design/tws_ram.sv
module tws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/tws_acc.sv
module tws_acc #(
  parameter int unsigned SB = 32,
  parameter int unsigned CW = 11,
  parameter int unsigned SW = 43
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clear_i,
  input  logic                                 valid_i,
  input  logic [tws_pkg::CHANNELS*SB-1:0]      samples_i,
  output logic [tws_pkg::CHANNELS*SW-1:0]      sum_o,
  output logic [tws_pkg::CHANNELS*CW-1:0]      n_o
);
  logic first_q, first_d;

  always_comb begin
    first_d = first_q;
    if (clear_i) begin
      first_d = 1'b1;
    end else if (valid_i) begin
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else begin
      first_q <= first_d;
    end
  end

  for (genvar c = 0; c < tws_pkg::CHANNELS; c++) begin : g_lane
    logic signed [SB-1:0] v;
    logic signed [SB-1:0] prev_q;
    logic signed [SW-1:0] sum_q, sum_d;
    logic [CW-1:0]        n_q, n_d;
    logic signed [SB:0]   diff;
    logic [SB:0]          absd;
    logic                 jump;

    assign v    = signed'(samples_i[c*SB +: SB]);
    assign diff = {prev_q[SB-1], prev_q} - {v[SB-1], v};
    assign absd = diff[SB] ? unsigned'(-diff) : unsigned'(diff);
    // angle channels restart after a jump larger than pi
    assign jump = (c < tws_pkg::WRAP_CHANNELS) && (64'(absd) > tws_pkg::PI_Q28);

    always_comb begin
      sum_d = sum_q;
      n_d   = n_q;
      if (valid_i) begin
        if (first_q || jump) begin
          sum_d = SW'(v);
          n_d   = CW'(1);
        end else begin
          sum_d = sum_q + SW'(v);
          n_d   = n_q + CW'(1);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      sum_q <= sum_d;
      n_q   <= n_d;
      if (valid_i) begin
        prev_q <= v;
      end
    end

    assign sum_o[c*SW +: SW] = sum_q;
    assign n_o[c*CW +: CW]   = n_q;
  end
endmodule

// File: design/tws_div.sv
module tws_div #(
  parameter int unsigned SW = 43,
  parameter int unsigned CW = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [SW-1:0] sum_i,
  input  logic [CW-1:0]        n_i,
  output logic                 done_o,
  output logic signed [SW-1:0] q_o
);
  localparam int unsigned DW  = SW + 1;
  localparam int unsigned CNW = $clog2(DW + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               neg_q, neg_d;
  logic [DW-1:0]      dvd_q, dvd_d;
  logic [CW-1:0]      rem_q, rem_d;
  logic [CW-1:0]      n_q, n_d;
  logic [CNW-1:0]     cnt_q, cnt_d;
  logic signed [DW-1:0] sx;
  logic [DW-1:0]      mag;
  logic [CW:0]        trial;

  assign sx    = DW'(sum_i);
  assign mag   = sx[DW-1] ? unsigned'(-sx) : unsigned'(sx);
  assign trial = {rem_q, dvd_q[DW-1]};

  // restoring division of the rounded magnitude, one quotient bit a cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    n_d    = n_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = sx[DW-1];
      dvd_d  = mag + DW'(n_i >> 1);
      rem_d  = '0;
      n_d    = n_i;
      cnt_d  = CNW'(DW);
    end else if (busy_q) begin
      if (trial >= {1'b0, n_q}) begin
        rem_d = CW'(trial - {1'b0, n_q});
        dvd_d = {dvd_q[DW-2:0], 1'b1};
      end else begin
        rem_d = CW'(trial);
        dvd_d = {dvd_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNW'(1);
      if (cnt_q == CNW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    n_q   <= n_d;
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? SW'(-dvd_q) : SW'(dvd_q);
endmodule

// File: design/time_window_attitude_smoother.sv
// Time-windowed moving average of bank, pitch, heading, latitude, longitude
// and altitude. Samples are kept with a time stamp in a ring buffer of DEPTH
// entries; stamps are stored against a running base so that shifting the
// window only moves the base. Per item, the drop walk reads the single-read
// stamp memory one entry at a time, the summing walk reads all entries
// through the sample memory read port, and one shared bit-serial divider
// forms the six rounded means of SW = SAMPLE_BITS + clog2(DEPTH) + 1 bit
// sums. The input is not ready while an item is at work.
module time_window_attitude_smoother #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tws_stream_if.sink   cfg_i,
  tws_stream_if.sink   in_i,
  tws_stream_if.source out_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH) + 1;
  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned SW = SB + CW;
  localparam int unsigned TW = tws_pkg::STAMP_W;
  localparam int unsigned NC = tws_pkg::CHANNELS;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return AW'(s);
  endfunction

  tws_pkg::state_e state_q, state_d;

  logic [tws_pkg::CFG_W-1:0] window_q, window_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   oldest_q, oldest_d;
  logic [TW-1:0]   base_q, base_d;
  logic [TW-1:0]   excess_q, excess_d;
  logic            shift_q, shift_d;
  logic [TW-1:0]   next_q, next_d;
  logic [15:0]     delta_q, delta_d;
  logic [NC*SB-1:0] samp_q, samp_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   k_q, k_d;
  logic            rd_valid_q, rd_valid_d;
  logic [tws_pkg::CH_W-1:0] ch_q, ch_d;
  logic            div_run_q, div_run_d;
  logic signed [SB-1:0] res_q [NC];
  logic signed [SB-1:0] res_d [NC];
  logic            out_valid_q, out_valid_d;
  tws_pkg::out_t   out_data_q, out_data_d;

  // memories
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   stamp_raddr;
  logic [TW-1:0]   stamp_rdata;
  logic [NC*SB-1:0] samp_rdata;

  logic [TW-1:0]   eff_stamp;
  logic signed [TW:0] excess;
  logic            acc_clear;
  logic [NC*SW-1:0] sums;
  logic [NC*CW-1:0] ns;
  logic            div_start, div_done;
  logic signed [SW-1:0] div_q;
  logic signed [31:0] fld [NC];
  logic [NC*SB-1:0] samp_in;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == tws_pkg::S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign fld[0] = in_i.data.bank_in;
  assign fld[1] = in_i.data.pitch_in;
  assign fld[2] = in_i.data.heading_in;
  assign fld[3] = in_i.data.lat_in;
  assign fld[4] = in_i.data.lon_in;
  assign fld[5] = in_i.data.alt_in;

  for (genvar c = 0; c < NC; c++) begin : g_cut
    assign samp_in[c*SB +: SB] = SB'(fld[c]);
  end

  assign eff_stamp = stamp_rdata - base_q;
  assign excess    = signed'({1'b0, eff_stamp}) - signed'((TW+1)'(window_q));

  always_comb begin
    state_d     = state_q;
    window_d    = window_q;
    count_d     = count_q;
    oldest_d    = oldest_q;
    base_d      = base_q;
    excess_d    = excess_q;
    shift_d     = shift_q;
    next_d      = next_q;
    delta_d     = delta_q;
    samp_d      = samp_q;
    ptr_d       = ptr_q;
    k_d         = k_q;
    rd_valid_d  = 1'b0;
    ch_d        = ch_q;
    div_run_d   = div_run_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = wrap_add(oldest_q, count_q);
    stamp_raddr = oldest_q;
    acc_clear   = 1'b0;
    div_start   = 1'b0;

    if (cfg_i.valid) begin
      window_d = cfg_i.data;
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tws_pkg::S_IDLE: begin
        if (in_i.valid) begin
          delta_d = in_i.data.time_delta_ms;
          samp_d  = samp_in;
          state_d = tws_pkg::S_LAST;
        end
      end
      tws_pkg::S_LAST: begin
        stamp_raddr = wrap_add(oldest_q, count_q - CW'(1));
        state_d     = tws_pkg::S_EXCESS;
      end
      tws_pkg::S_EXCESS: begin
        if (count_q != '0 && excess > 0) begin
          excess_d = TW'(excess);
          shift_d  = 1'b1;
          next_d   = TW'(window_q) + TW'(delta_q);
          state_d  = tws_pkg::S_DROP_RD;
        end else if (count_q != '0) begin
          shift_d  = 1'b0;
          next_d   = eff_stamp + TW'(delta_q);
          state_d  = tws_pkg::S_FULL;
        end else begin
          // empty buffer: newest stamp counts as zero
          shift_d  = 1'b0;
          next_d   = TW'(delta_q);
          state_d  = tws_pkg::S_FULL;
        end
      end
      tws_pkg::S_DROP_RD: begin
        stamp_raddr = oldest_q;
        state_d     = (count_q == '0) ? tws_pkg::S_FULL : tws_pkg::S_DROP_CHK;
      end
      tws_pkg::S_DROP_CHK: begin
        if (eff_stamp < excess_q) begin
          oldest_d = wrap_add(oldest_q, CW'(1));
          count_d  = count_q - CW'(1);
          state_d  = tws_pkg::S_DROP_RD;
        end else begin
          state_d  = tws_pkg::S_FULL;
        end
      end
      tws_pkg::S_FULL: begin
        if (shift_q) begin
          base_d = base_q + excess_q;
        end
        if (count_q >= CW'(DEPTH)) begin
          oldest_d = wrap_add(oldest_q, CW'(1));
          count_d  = count_q - CW'(1);
        end
        state_d = tws_pkg::S_APPEND;
      end
      tws_pkg::S_APPEND: begin
        mem_we    = 1'b1;
        count_d   = count_q + CW'(1);
        ptr_d     = oldest_q;
        k_d       = '0;
        acc_clear = 1'b1;
        state_d   = tws_pkg::S_SUM;
      end
      tws_pkg::S_SUM: begin
        rd_valid_d = 1'b1;
        ptr_d      = wrap_add(ptr_q, CW'(1));
        k_d        = k_q + CW'(1);
        if (k_q == count_q - CW'(1)) begin
          state_d = tws_pkg::S_SUM_END;
        end
      end
      tws_pkg::S_SUM_END: begin
        ch_d      = '0;
        div_run_d = 1'b0;
        state_d   = tws_pkg::S_DIV;
      end
      tws_pkg::S_DIV: begin
        if (!div_run_q) begin
          div_start = 1'b1;
          div_run_d = 1'b1;
        end else if (div_done) begin
          res_d[ch_q] = SB'(div_q);
          div_run_d   = 1'b0;
          ch_d        = ch_q + tws_pkg::CH_W'(1);
          if (ch_q == tws_pkg::CH_W'(NC - 1)) begin
            state_d = tws_pkg::S_OUT;
          end
        end
      end
      tws_pkg::S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d            = 1'b1;
          out_data_d.bank_avg    = 32'(res_q[0]);
          out_data_d.pitch_avg   = 32'(res_q[1]);
          out_data_d.heading_avg = 32'(res_q[2]);
          out_data_d.lat_avg     = 32'(res_q[3]);
          out_data_d.lon_avg     = 32'(res_q[4]);
          out_data_d.alt_avg     = 32'(res_q[5]);
          state_d                = tws_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tws_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tws_pkg::S_IDLE;
      window_q    <= tws_pkg::WINDOW_RESET;
      count_q     <= '0;
      oldest_q    <= '0;
      base_q      <= '0;
      rd_valid_q  <= 1'b0;
      div_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
      k_q         <= '0;
      shift_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      count_q     <= count_d;
      oldest_q    <= oldest_d;
      base_q      <= base_d;
      rd_valid_q  <= rd_valid_d;
      div_run_q   <= div_run_d;
      out_valid_q <= out_valid_d;
      ch_q        <= ch_d;
      k_q         <= k_d;
      shift_q     <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    excess_q   <= excess_d;
    next_q     <= next_d;
    delta_q    <= delta_d;
    samp_q     <= samp_d;
    ptr_q      <= ptr_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  tws_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (next_q + base_q),
    .raddr_i (stamp_raddr),
    .rdata_o (stamp_rdata)
  );

  tws_ram #(.WIDTH(NC*SB), .DEPTH(DEPTH)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (samp_q),
    .raddr_i (ptr_q),
    .rdata_o (samp_rdata)
  );

  tws_acc #(.SB(SB), .CW(CW), .SW(SW)) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (acc_clear),
    .valid_i   (rd_valid_q),
    .samples_i (samp_rdata),
    .sum_o     (sums),
    .n_o       (ns)
  );

  tws_div #(.SW(SW), .CW(CW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (signed'(sums[ch_q*SW +: SW])),
    .n_i     (ns[ch_q*CW +: CW]),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_oldest_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q < AW'(DEPTH - 1) || oldest_q == AW'(DEPTH - 1))
    else $error("oldest slot out of range");

  a_append_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tws_pkg::S_APPEND) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("append did not add an entry");

  a_div_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == tws_pkg::S_DIV))
    else $error("divider finished outside the divide phase");
endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned BUF_DEPTH  = 1024;
  localparam int unsigned STALL_LIMIT = 40000;
  localparam logic [tws_pkg::STAMP_W-1:0] STAMP_MASK = '1;

  typedef struct {
    longint stamp;
    longint chan[tws_pkg::CHANNELS];
  } entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tws_stream_if #(.T(logic [tws_pkg::CFG_W-1:0])) cfg_if ();
  tws_stream_if #(.T(tws_pkg::in_t))              in_if ();
  tws_stream_if #(.T(tws_pkg::out_t))             out_if ();

  time_window_attitude_smoother i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  longint unsigned window_len = tws_pkg::WINDOW_RESET;
  entry_t          window_buf[$];
  tws_pkg::out_t   pending_avgs[$];

  int unsigned mismatches = 0;
  bit          src_gaps = 1'b0;
  bit          snk_stalls = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
  end

  function automatic longint rounded_avg(longint sum, longint n);
    longint mag;
    mag = (sum < 0) ? -sum : sum;
    mag = (mag + n / 2) / n;
    return (sum < 0) ? -mag : mag;
  endfunction

  // updates the buffer with one item and returns the averages it produces
  function automatic tws_pkg::out_t smooth_item(tws_pkg::in_t x);
    longint last, excess, next_stamp, sum, d;
    int     brk;
    entry_t e;
    tws_pkg::out_t r;
    logic [31:0] res [tws_pkg::CHANNELS];
    last = (window_buf.size() > 0) ? window_buf[$].stamp : 0;
    excess = last - longint'(window_len);
    next_stamp = last + longint'(x.time_delta_ms);
    if (excess > 0) begin
      next_stamp -= excess;
      while (window_buf.size() > 0 && window_buf[0].stamp < excess)
        void'(window_buf.pop_front());
      foreach (window_buf[k])
        window_buf[k].stamp = (window_buf[k].stamp - excess) & longint'(STAMP_MASK);
    end
    if (window_buf.size() >= BUF_DEPTH) void'(window_buf.pop_front());
    e.stamp = next_stamp & longint'(STAMP_MASK);
    e.chan[0] = x.bank_in;
    e.chan[1] = x.pitch_in;
    e.chan[2] = x.heading_in;
    e.chan[3] = x.lat_in;
    e.chan[4] = x.lon_in;
    e.chan[5] = x.alt_in;
    window_buf.insert(window_buf.size(), e);
    for (int ch = 0; ch < tws_pkg::CHANNELS; ch++) begin
      sum = 0;
      brk = 0;
      foreach (window_buf[k]) begin
        if (ch < tws_pkg::WRAP_CHANNELS && k > 0) begin
          d = window_buf[k-1].chan[ch] - window_buf[k].chan[ch];
          if (d < 0) d = -d;
          if (d > longint'(tws_pkg::PI_Q28)) begin
            sum = 0;
            brk = k;
          end
        end
        sum += window_buf[k].chan[ch];
      end
      res[ch] = 32'(rounded_avg(sum, window_buf.size() - brk));
    end
    r = '{res[0], res[1], res[2], res[3], res[4], res[5]};
    return r;
  endfunction

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    int unsigned burst;
    burst = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_if.ready <= 1'b0;
      end else if (snk_stalls && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    tws_pkg::out_t want, got;
    logic [31:0]   w, g;
    if (out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_avgs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected item %h", got);
      end else begin
        want = pending_avgs.pop_front();
        for (int ch = 0; ch < tws_pkg::CHANNELS; ch++) begin
          w = want[32*(tws_pkg::CHANNELS-1-ch) +: 32];
          g = got[32*(tws_pkg::CHANNELS-1-ch) +: 32];
          if (w !== g) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tb: channel %0d expected %h got %h", ch, w, g);
          end
        end
      end
    end
  end

  task automatic send_item(tws_pkg::in_t x);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= x;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_avgs.insert(pending_avgs.size(), smooth_item(x));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_avgs.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_window(logic [tws_pkg::CFG_W-1:0] v);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    window_len = v;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_sample(bit angle);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return angle ? 32'($signed($urandom_range(0, 1600000000)) - 800000000)
                      : $urandom();
      default: return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  function automatic tws_pkg::in_t rand_item(int unsigned max_delta);
    tws_pkg::in_t x;
    x.time_delta_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                   : 16'($urandom_range(0, max_delta));
    x.bank_in    = rand_sample(1);
    x.pitch_in   = rand_sample(1);
    x.heading_in = rand_sample(1);
    x.lat_in     = rand_sample(0);
    x.lon_in     = rand_sample(0);
    x.alt_in     = rand_sample(0);
    return x;
  endfunction

  function automatic tws_pkg::in_t flat_item(logic [15:0] dt, logic [31:0] v);
    tws_pkg::in_t x;
    x = '{dt, v, v, v, v, v, v};
    return x;
  endfunction

  task automatic test_directed_extremes();
    send_item(flat_item(16'd0, 32'h7fff_ffff));
    send_item(flat_item(16'd0, 32'h7fff_ffff));
    send_item(flat_item(16'd1, 32'h8000_0000));   // jump far beyond pi
    send_item(flat_item(16'd0, 32'h8000_0000));
    send_item(flat_item(16'd10, 32'd0));
    // differences of exactly pi and one above it
    send_item(flat_item(16'd10, 32'd843314856));
    send_item(flat_item(16'd10, 32'd1686629713));
    // rounding ties of both signs
    write_window(16'd1);
    send_item(flat_item(16'd0, 32'd1));
    send_item(flat_item(16'd0, 32'd2));
    send_item(flat_item(16'd5, 32'hffff_ffff));
    send_item(flat_item(16'd0, 32'hffff_fffe));
    send_item(flat_item(16'hffff, 32'd3));          // pushes everything out
    send_item(flat_item(16'd0, 32'd4));
  endtask

  task automatic test_window_zero();
    write_window(16'd0);
    for (int i = 0; i < 6; i++) send_item(rand_item(3));
    write_window(16'hffff);
    for (int i = 0; i < 6; i++) send_item(rand_item(20000));
    write_window(tws_pkg::WINDOW_RESET);
  endtask

  task automatic test_long_buffer();
    write_window(16'hffff);
    src_gaps = 1'b1;
    snk_stalls = 1'b1;
    for (int i = 0; i < 200; i++) begin
      tws_pkg::in_t x;
      x = rand_item(0);
      x.time_delta_ms = 16'd0;
      send_item(x);
    end
    write_window(16'd1);   // shrinks the window; the zero-delta items share the newest stamp and stay
    send_item(rand_item(5));
  endtask

  task automatic test_backpressure();
    write_window(16'd200);
    hold_left = 3000;
    for (int i = 0; i < 8; i++) send_item(rand_item(50));
  endtask

  task automatic test_random();
    int unsigned w;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: w = 1;
        1: w = 65535;
        default: w = $urandom_range(2, 3000);
      endcase
      write_window(16'(w));
      if (phase == 5) begin
        src_gaps = 1'b0;
        snk_stalls = 1'b0;
      end
      for (int i = 0; i < 45; i++) send_item(rand_item((w < 30) ? w : w / 10));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_window_zero();
    test_long_buffer();
    test_backpressure();
    test_random();
    drain();
    repeat (2000) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
